FILE: rtl/cci_pkg.sv
// cci_pkg: shared constants, case codes and sideband types of the circle intersection block
// no dependencies; used by the top and the checker of the block
package cci_pkg;

    localparam int FRACTION_BITS_DEF = 16;

    // case codes of the result
    localparam logic [2:0] CASE_INTERSECT  = 3'd0;
    localparam logic [2:0] CASE_APART      = 3'd1;
    localparam logic [2:0] CASE_NESTED     = 3'd2;
    localparam logic [2:0] CASE_IDENTICAL  = 3'd3;
    localparam logic [2:0] CASE_CONCENTRIC = 3'd4;

    localparam logic [1:0] COUNT_NONE = 2'd0;
    localparam logic [1:0] COUNT_ONE  = 2'd1;
    localparam logic [1:0] COUNT_TWO  = 2'd2;

    // datapath widths, sized for the largest fraction width
    localparam int SQ_W  = 128;   // square root operand
    localparam int QUO_W = 100;   // divider dividend and quotient
    localparam int DEN_W = 68;    // divider divisor
    localparam int D2_W  = 67;    // squared centre distance
    localparam int LANES = 4;     // point coordinates per result

    localparam logic [40:0] OFFSET_CAP = 41'h100_0000_0000;

    typedef struct packed {
        logic [2:0]        code;
        logic              first_small;
        logic [31:0]       x1;
        logic [31:0]       y1;
        logic [31:0]       sxp;
        logic [31:0]       syp;
        logic [31:0]       mid_x;
        logic [31:0]       mid_y;
        logic [32:0]       dx;
        logic [32:0]       dy;
        logic [63:0]       am;
        logic              aneg;
        logic [31:0]       sum;
        logic [D2_W-1:0]   d2;
    } t_sq_side;

    typedef struct packed {
        logic [2:0]        code;
        logic [LANES-1:0]  neg;
        logic [31:0]       base_x;
        logic [31:0]       base_y;
        logic [31:0]       mid_x;
        logic [31:0]       mid_y;
    } t_dv_side;

endpackage

FILE: rtl/cci_sqrt.sv
// cci_sqrt: pipelined floor square root, one root bit per register stage
// generic widths; carries an opaque tag alongside each operand
module cci_sqrt #(
    parameter int W  = 128,
    parameter int TW = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [W-1:0]   i_val,
    input  logic [TW-1:0]  i_tag,
    output logic           o_valid,
    output logic [W/2-1:0] o_root,
    output logic [W-1:0]   o_rem,
    output logic [TW-1:0]  o_tag
);
    localparam int N = W / 2;

    logic [W-1:0]  r_n   [N+1];
    logic [W-1:0]  r_res [N+1];
    logic [TW-1:0] r_tag [N+1];
    logic          r_v   [N+1];

    assign r_n[0]   = i_val;
    assign r_res[0] = '0;
    assign r_tag[0] = i_tag;
    assign r_v[0]   = i_valid;

    for (genvar k = 0; k < N; k++) begin : g_step
        localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * k);
        logic [W-1:0] s;
        logic         take;
        assign s    = r_res[k] + ONE;
        assign take = (r_n[k] >= s);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k+1]   <= take ? r_n[k] - s : r_n[k];
                r_res[k+1] <= take ? (r_res[k] >> 1) + ONE : r_res[k] >> 1;
                r_tag[k+1] <= r_tag[k];
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_root  = r_res[N][N-1:0];
    assign o_rem   = r_n[N];
    assign o_tag   = r_tag[N];

endmodule

FILE: rtl/cci_div.sv
// cci_div: pipelined restoring divider over several lanes, one quotient bit per stage
// generic widths; carries an opaque tag alongside each set of operands
module cci_div #(
    parameter int NW = 100,
    parameter int DW = 68,
    parameter int TW = 8,
    parameter int L  = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [L-1:0][NW-1:0]  i_num,
    input  logic [L-1:0][DW-1:0]  i_den,
    input  logic [TW-1:0]         i_tag,
    output logic                  o_valid,
    output logic [L-1:0][NW-1:0]  o_quo,
    output logic [TW-1:0]         o_tag
);
    logic [NW-1:0] r_num [NW+1][L];
    logic [DW-1:0] r_rem [NW+1][L];
    logic [DW-1:0] r_den [NW+1][L];
    logic [TW-1:0] r_tag [NW+1];
    logic          r_v   [NW+1];

    assign r_tag[0] = i_tag;
    assign r_v[0]   = i_valid;

    for (genvar l = 0; l < L; l++) begin : g_in
        assign r_num[0][l] = i_num[l];
        assign r_rem[0][l] = '0;
        assign r_den[0][l] = i_den[l];
        assign o_quo[l]    = r_num[NW][l];
    end

    for (genvar s = 0; s < NW; s++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[s+1] <= r_tag[s];
            end
        end

        for (genvar l = 0; l < L; l++) begin : g_lane
            logic [DW:0] sh;
            logic [DW:0] diff;
            logic        take;
            assign sh   = {r_rem[s][l], r_num[s][l][NW-1]};
            assign take = (sh >= {1'b0, r_den[s][l]});
            assign diff = sh - {1'b0, r_den[s][l]};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s+1][l] <= take ? diff[DW-1:0] : sh[DW-1:0];
                    r_num[s+1][l] <= {r_num[s][l][NW-2:0], take};
                    r_den[s+1][l] <= r_den[s][l];
                end
            end
        end
    end

    assign o_valid = r_v[NW];
    assign o_tag   = r_tag[NW];

endmodule

FILE: rtl/circle_circle_intersection_top.sv
// circle_circle_intersection_top: the path from input transaction to result valid is made of
// 7 front stages, the 64-stage square root, 3 product stages, the 100-stage divider
// and the output register. throughput one transaction per cycle; a stalled output holds the
// whole pipeline. synchronous active-low reset clears all valid bits; data regs are not reset.
module circle_circle_intersection_top
    import cci_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // first_x, first_y, first_radius, second_x, second_y, second_radius, zero pad
    input  logic [191:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // point_a_x, point_a_y, point_b_x, point_b_y, point_count, case_code, zero pad
    output logic [135:0] o_m_axis_tdata
);
    localparam int SQ_TW = $bits(t_sq_side);
    localparam int DV_TW = $bits(t_dv_side);

    function automatic logic [32:0] abs33(input logic [32:0] v);
        abs33 = v[32] ? (~v + 33'd1) : v;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [42:0] v);
        if (v > 43'sd2147483647) sat32 = 32'h7fff_ffff;
        else if (v < -43'sd2147483648) sat32 = 32'h8000_0000;
        else sat32 = v[31:0];
    endfunction

    logic en;
    logic r_out_v;
    logic [135:0] r_out_data;

    assign en = !r_out_v || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // stage 1: input register
    logic r1_v;
    logic [31:0] r1_x1, r1_y1, r1_x2, r1_y2;
    logic [30:0] r1_r1, r1_r2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (en) r1_v <= i_s_axis_tvalid;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_x1 <= i_s_axis_tdata[31:0];
            r1_y1 <= i_s_axis_tdata[63:32];
            r1_r1 <= i_s_axis_tdata[94:64];
            r1_x2 <= i_s_axis_tdata[126:95];
            r1_y2 <= i_s_axis_tdata[158:127];
            r1_r2 <= i_s_axis_tdata[189:159];
        end
    end

    // stage 2: differences, radius sum and gap, centre midpoint
    logic r2_v;
    logic [31:0] r2_x1, r2_y1, r2_x2, r2_y2, r2_sum, r2_mid_x, r2_mid_y;
    logic [30:0] r2_r1, r2_r2, r2_diff;
    logic [32:0] r2_dx, r2_dy;
    logic [32:0] n2_sx, n2_sy;

    assign n2_sx = {r1_x1[31], r1_x1} + {r1_x2[31], r1_x2};
    assign n2_sy = {r1_y1[31], r1_y1} + {r1_y2[31], r1_y2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (en) r2_v <= r1_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_x1    <= r1_x1;
            r2_y1    <= r1_y1;
            r2_x2    <= r1_x2;
            r2_y2    <= r1_y2;
            r2_r1    <= r1_r1;
            r2_r2    <= r1_r2;
            r2_dx    <= {r1_x2[31], r1_x2} - {r1_x1[31], r1_x1};
            r2_dy    <= {r1_y2[31], r1_y2} - {r1_y1[31], r1_y1};
            r2_sum   <= {1'b0, r1_r1} + {1'b0, r1_r2};
            r2_diff  <= (r1_r1 > r1_r2) ? r1_r1 - r1_r2 : r1_r2 - r1_r1;
            // arithmetic shift rounds toward minus infinity
            r2_mid_x <= n2_sx[32:1];
            r2_mid_y <= n2_sy[32:1];
        end
    end

    // stage 3: squares
    logic r3_v;
    logic [65:0] r3_dxsq, r3_dysq;
    logic [63:0] r3_sumsq;
    logic [61:0] r3_diffsq, r3_r1sq, r3_r2sq;
    logic [31:0] r3_x1, r3_y1, r3_x2, r3_y2, r3_sum, r3_mid_x, r3_mid_y;
    logic [32:0] r3_dx, r3_dy;
    logic r3_first_small;
    logic [32:0] n3_adx, n3_ady;

    assign n3_adx = abs33(r2_dx);
    assign n3_ady = abs33(r2_dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (en) r3_v <= r2_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_dxsq        <= n3_adx * n3_adx;
            r3_dysq        <= n3_ady * n3_ady;
            r3_sumsq       <= r2_sum * r2_sum;
            r3_diffsq      <= r2_diff * r2_diff;
            r3_r1sq        <= r2_r1 * r2_r1;
            r3_r2sq        <= r2_r2 * r2_r2;
            r3_x1          <= r2_x1;
            r3_y1          <= r2_y1;
            r3_x2          <= r2_x2;
            r3_y2          <= r2_y2;
            r3_sum         <= r2_sum;
            r3_mid_x       <= r2_mid_x;
            r3_mid_y       <= r2_mid_y;
            r3_dx          <= r2_dx;
            r3_dy          <= r2_dy;
            r3_first_small <= (r2_r1 < r2_r2);
        end
    end

    // stage 4: distance, case decision, power term
    logic r4_v;
    t_sq_side r4_side;
    logic [61:0] r4_r1sq;
    logic [D2_W-1:0] n4_d2;
    logic [67:0] n4_a, n4_a_neg;
    logic [2:0] n4_code;

    assign n4_d2    = {1'b0, r3_dxsq} + {1'b0, r3_dysq};
    assign n4_a     = {1'b0, n4_d2} + {6'b0, r3_r1sq} - {6'b0, r3_r2sq};
    assign n4_a_neg = -n4_a;

    always_comb begin
        if (n4_d2 > {3'b0, r3_sumsq}) begin
            n4_code = CASE_APART;
        end else if (n4_d2 < {5'b0, r3_diffsq}) begin
            n4_code = (n4_d2 == '0) ? CASE_CONCENTRIC : CASE_NESTED;
        end else if (n4_d2 == '0) begin
            n4_code = CASE_IDENTICAL;
        end else begin
            n4_code = CASE_INTERSECT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (en) r4_v <= r3_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_side.code        <= n4_code;
            r4_side.first_small <= r3_first_small;
            r4_side.x1          <= r3_x1;
            r4_side.y1          <= r3_y1;
            r4_side.sxp         <= r3_first_small ? r3_x1 : r3_x2;
            r4_side.syp         <= r3_first_small ? r3_y1 : r3_y2;
            r4_side.mid_x       <= r3_mid_x;
            r4_side.mid_y       <= r3_mid_y;
            r4_side.dx          <= r3_dx;
            r4_side.dy          <= r3_dy;
            r4_side.am          <= n4_a[67] ? n4_a_neg[63:0] : n4_a[63:0];
            r4_side.aneg        <= n4_a[67];
            r4_side.sum         <= r3_sum;
            r4_side.d2          <= n4_d2;
            r4_r1sq             <= r3_r1sq;
        end
    end

    // stage 5a: 32 by 32 partial products of 4 r1^2 d2 and a^2
    logic r5a_v;
    t_sq_side r5a_side;
    logic [63:0] r5a_bhh, r5a_bhl, r5a_blh, r5a_bll, r5a_ahh, r5a_ahl, r5a_all;
    logic [63:0] n5_r1sq4;
    logic [63:0] n5_d2lo;

    assign n5_r1sq4 = {r4_r1sq, 2'b00};
    assign n5_d2lo  = r4_side.d2[63:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5a_v <= 1'b0;
        else if (en) r5a_v <= r4_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5a_bhh  <= n5_r1sq4[63:32] * n5_d2lo[63:32];
            r5a_bhl  <= n5_r1sq4[63:32] * n5_d2lo[31:0];
            r5a_blh  <= n5_r1sq4[31:0] * n5_d2lo[63:32];
            r5a_bll  <= n5_r1sq4[31:0] * n5_d2lo[31:0];
            r5a_ahh  <= r4_side.am[63:32] * r4_side.am[63:32];
            r5a_ahl  <= r4_side.am[63:32] * r4_side.am[31:0];
            r5a_all  <= r4_side.am[31:0] * r4_side.am[31:0];
            r5a_side <= r4_side;
        end
    end

    // stage 5: partial products summed
    logic r5_v;
    t_sq_side r5_side;
    logic [127:0] r5_big, r5_asq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (en) r5_v <= r5a_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_big  <= {r5a_bhh, 64'b0} + {32'b0, r5a_bhl, 32'b0}
                     + {32'b0, r5a_blh, 32'b0} + {64'b0, r5a_bll};
            // cross term appears twice, hence the extra shift
            r5_asq  <= {r5a_ahh, 64'b0} + {31'b0, r5a_ahl, 33'b0} + {64'b0, r5a_all};
            r5_side <= r5a_side;
        end
    end

    // stage 6: clamped h or scaled distance into the root unit
    logic r6_v;
    t_sq_side r6_side;
    logic [SQ_W-1:0] r6_sq_in;
    logic [SQ_W-1:0] n6_d2_sh;

    assign n6_d2_sh = {{(SQ_W-D2_W){1'b0}}, r5_side.d2} << (2 * FRACTION_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else if (en) r6_v <= r5_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r5_side.code == CASE_NESTED) r6_sq_in <= n6_d2_sh;
            else if (r5_big > r5_asq) r6_sq_in <= r5_big - r5_asq;
            else r6_sq_in <= '0;
            r6_side <= r5_side;
        end
    end

    logic sq_v;
    logic [SQ_W/2-1:0] sq_root;
    logic [SQ_W-1:0] sq_rem;
    logic [SQ_TW-1:0] sq_tag;
    t_sq_side sq_side;

    cci_sqrt #(
        .W  (SQ_W),
        .TW (SQ_TW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r6_v),
        .i_val   (r6_sq_in),
        .i_tag   (r6_side),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_rem   (sq_rem),
        .o_tag   (sq_tag)
    );

    assign sq_side = t_sq_side'(sq_tag);

    // stage 7a: partial products with the centre offsets, multiplier split in halves
    logic r7a_v;
    t_sq_side r7a_side;
    logic [63:0] r7a_root;
    logic [64:0] r7a_axl, r7a_axh, r7a_ayl, r7a_ayh, r7a_sxl, r7a_sxh, r7a_syl, r7a_syh;
    logic [63:0] n7_sm, n7_t, n7_ma;
    logic [32:0] n7_adx, n7_ady;

    assign n7_sm  = sq_root + {63'b0, (sq_rem > {64'b0, sq_root})};
    assign n7_t   = ({32'b0, sq_side.sum} << FRACTION_BITS) - sq_root;
    assign n7_ma  = (sq_side.code == CASE_NESTED) ? n7_t : sq_side.am;
    assign n7_adx = abs33(sq_side.dx);
    assign n7_ady = abs33(sq_side.dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7a_v <= 1'b0;
        else if (en) r7a_v <= sq_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r7a_axl  <= n7_ma[31:0] * n7_adx;
            r7a_axh  <= n7_ma[63:32] * n7_adx;
            r7a_ayl  <= n7_ma[31:0] * n7_ady;
            r7a_ayh  <= n7_ma[63:32] * n7_ady;
            r7a_sxl  <= n7_sm[31:0] * n7_adx;
            r7a_sxh  <= n7_sm[63:32] * n7_adx;
            r7a_syl  <= n7_sm[31:0] * n7_ady;
            r7a_syh  <= n7_sm[63:32] * n7_ady;
            r7a_root <= sq_root;
            r7a_side <= sq_side;
        end
    end

    // stage 7: products with the centre offsets
    logic r7_v;
    t_sq_side r7_side;
    logic [63:0] r7_root;
    logic [96:0] r7_p_ax, r7_p_ay, r7_p_sx, r7_p_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0;
        else if (en) r7_v <= r7a_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_p_ax <= {r7a_axh, 32'b0} + {32'b0, r7a_axl};
            r7_p_ay <= {r7a_ayh, 32'b0} + {32'b0, r7a_ayl};
            r7_p_sx <= {r7a_sxh, 32'b0} + {32'b0, r7a_sxl};
            r7_p_sy <= {r7a_syh, 32'b0} + {32'b0, r7a_syl};
            r7_root <= r7a_root;
            r7_side <= r7a_side;
        end
    end

    // stage 8: signed numerators, magnitudes and divider operands
    logic r8_v;
    t_dv_side r8_side;
    logic [LANES-1:0][QUO_W-1:0] r8_num;
    logic [LANES-1:0][DEN_W-1:0] r8_den;
    logic [99:0] n8_tax, n8_tay, n8_tsx, n8_tsy;
    logic [99:0] n8_n [LANES];
    logic [99:0] n8_mag [LANES];
    logic [LANES-1:0] n8_neg;
    logic [D2_W-1:0] n8_d;
    logic n8_nested;

    assign n8_nested = (r7_side.code == CASE_NESTED);
    assign n8_tax = (r7_side.aneg ^ r7_side.dx[32]) ? -{3'b0, r7_p_ax} : {3'b0, r7_p_ax};
    assign n8_tay = (r7_side.aneg ^ r7_side.dy[32]) ? -{3'b0, r7_p_ay} : {3'b0, r7_p_ay};
    assign n8_tsx = r7_side.dx[32] ? -{3'b0, r7_p_sx} : {3'b0, r7_p_sx};
    assign n8_tsy = r7_side.dy[32] ? -{3'b0, r7_p_sy} : {3'b0, r7_p_sy};
    assign n8_n[0] = n8_tax + n8_tsy;
    assign n8_n[1] = n8_tay - n8_tsx;
    assign n8_n[2] = n8_tax - n8_tsy;
    assign n8_n[3] = n8_tay + n8_tsx;
    assign n8_d = n8_nested ? {3'b0, r7_root} : r7_side.d2;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n8_neg[l] = n8_n[l][99];
            n8_mag[l] = n8_n[l][99] ? -n8_n[l] : n8_n[l];
        end
        if (n8_nested) begin
            // offset from the smaller centre points away from the larger one
            n8_mag[0] = {3'b0, r7_p_ax};
            n8_mag[1] = {3'b0, r7_p_ay};
            n8_neg[0] = r7_side.first_small ? (!r7_side.dx[32] && r7_side.dx != '0)
                                            : r7_side.dx[32];
            n8_neg[1] = r7_side.first_small ? (!r7_side.dy[32] && r7_side.dy != '0)
                                            : r7_side.dy[32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r8_v <= 1'b0;
        else if (en) r8_v <= r7_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                r8_num[l] <= n8_mag[l] + {{(QUO_W-D2_W){1'b0}}, n8_d};
                r8_den[l] <= {n8_d, 1'b0};
            end
            r8_side.code   <= r7_side.code;
            r8_side.neg    <= n8_neg;
            r8_side.base_x <= n8_nested ? r7_side.sxp : r7_side.x1;
            r8_side.base_y <= n8_nested ? r7_side.syp : r7_side.y1;
            r8_side.mid_x  <= r7_side.mid_x;
            r8_side.mid_y  <= r7_side.mid_y;
        end
    end

    logic dv_v;
    logic [LANES-1:0][QUO_W-1:0] dv_quo;
    logic [DV_TW-1:0] dv_tag;
    t_dv_side dv_side;

    cci_div #(
        .NW (QUO_W),
        .DW (DEN_W),
        .TW (DV_TW),
        .L  (LANES)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r8_v),
        .i_num   (r8_num),
        .i_den   (r8_den),
        .i_tag   (r8_side),
        .o_valid (dv_v),
        .o_quo   (dv_quo),
        .o_tag   (dv_tag)
    );

    assign dv_side = t_dv_side'(dv_tag);

    // output stage: cap, sign, add base, saturate, select by case
    logic [31:0] n9_pt [LANES];
    logic [135:0] n9_data;
    logic [31:0] n9_ax, n9_ay, n9_bx, n9_by;
    logic [1:0] n9_cnt;

    always_comb begin
        logic [40:0] cap;
        logic [41:0] off;
        logic [31:0] base;
        for (int l = 0; l < LANES; l++) begin
            cap  = (dv_quo[l] > {{(QUO_W-41){1'b0}}, OFFSET_CAP}) ? OFFSET_CAP
                                                                   : dv_quo[l][40:0];
            off  = dv_side.neg[l] ? -{1'b0, cap} : {1'b0, cap};
            base = l[0] ? dv_side.base_y : dv_side.base_x;
            n9_pt[l] = sat32($signed({{11{base[31]}}, base} + {off[41], off}));
        end
    end

    always_comb begin
        n9_ax  = '0;
        n9_ay  = '0;
        n9_bx  = '0;
        n9_by  = '0;
        n9_cnt = COUNT_ONE;
        case (dv_side.code)
            CASE_APART: begin
                n9_ax = dv_side.mid_x;
                n9_ay = dv_side.mid_y;
            end
            CASE_CONCENTRIC: begin
                n9_ax = dv_side.base_x;
                n9_ay = dv_side.base_y;
            end
            CASE_NESTED: begin
                n9_ax = n9_pt[0];
                n9_ay = n9_pt[1];
            end
            CASE_INTERSECT: begin
                n9_ax  = n9_pt[0];
                n9_ay  = n9_pt[1];
                n9_bx  = n9_pt[2];
                n9_by  = n9_pt[3];
                n9_cnt = COUNT_TWO;
            end
            default: begin
                n9_cnt = COUNT_NONE;
            end
        endcase
    end

    assign n9_data = {3'b000, dv_side.code, n9_cnt, n9_by, n9_bx, n9_ay, n9_ax};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_v <= 1'b0;
        else if (en) r_out_v <= dv_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) r_out_data <= n9_data;
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;

endmodule

FILE: rtl/cci_checker.sv
// cci_checker: port-level assertions for the circle intersection block, bound to the top
// depends on cci_pkg for case and count codes
module cci_checker
    import cci_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [135:0] i_m_axis_tdata
);
    logic [1:0] cnt;
    logic [2:0] code;

    assign cnt  = i_m_axis_tdata[129:128];
    assign code = i_m_axis_tdata[132:130];

    // no result right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled transaction holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=> i_m_axis_tvalid && $stable(i_m_axis_tdata))
        else $error("stalled result changed");

    // two points only for intersecting circles, none only for identical ones
    a_count_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid |-> ((cnt == COUNT_TWO) == (code == CASE_INTERSECT)) &&
                            ((cnt == COUNT_NONE) == (code == CASE_IDENTICAL)))
        else $error("point count does not match case");

    // second point is zero unless two points
    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && cnt != COUNT_TWO |-> i_m_axis_tdata[127:64] == '0)
        else $error("unused point not zero");

    // identical circles give no first point either
    a_identical_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && code == CASE_IDENTICAL |-> i_m_axis_tdata[63:0] == '0)
        else $error("identical case point not zero");

endmodule

bind circle_circle_intersection_top cci_checker u_cci_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata)
);

FILE: tb/sv/tb_top.sv
// tb_top: self-checking testbench for circle_circle_intersection_top
// depends on rtl/cci_pkg.sv and rtl/circle_circle_intersection_top.sv
`timescale 1ns / 100ps

module tb_top;
    import cci_pkg::*;

    localparam int FRAC       = 16;
    localparam int DRAIN_WAIT = 220;     // a bit beyond the pipeline latency
    localparam int DOG_LIMIT  = 20000;
    localparam int HOLD_LEN   = 600;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    // first_x, first_y, first_radius, second_x, second_y, second_radius, zero pad
    logic [191:0] i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    // point_a_x, point_a_y, point_b_x, point_b_y, point_count, case_code, zero pad
    logic [135:0] o_m_axis_tdata;

    logic [135:0] result_fifo[$];
    int           mismatches = 0;
    int           idle_mode = 0;     // 0 none, 1 sender, 2 receiver, 3 both
    int           hold_count = 0;
    int           dog = 0;

    circle_circle_intersection_top #(.FRACTION_BITS(FRAC)) DUT (.*);

    always #2 i_clk = ~i_clk;

    // ---------------- predictor ----------------
    function automatic logic [127:0] isqrt(input logic [127:0] n, output logic [127:0] rem);
        logic [127:0] res, trial;
        res = '0;
        for (int i = 63; i >= 0; i--) begin
            trial = res | (128'd1 << i);
            if (trial * trial <= n) res = trial;
        end
        rem = n - res * res;
        return res;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'h7fff_ffff;
        if (v < -128'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [127:0] capped(input logic [127:0] q, input bit neg);
        logic [127:0] m;
        m = (q > (128'd1 << 40)) ? (128'd1 << 40) : q;
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [127:0] signed_prod(input logic [63:0] am, input bit aneg,
                                                 input longint b);
        logic [127:0] p;
        p = 128'(am) * 128'(b < 0 ? -b : b);
        return (aneg != (b < 0)) ? -p : p;
    endfunction

    function automatic logic [31:0] offset_point(input longint base, input logic [127:0] n,
                                                 input logic [127:0] d2);
        bit neg;
        logic [127:0] m;
        neg = n[127];
        m = neg ? -n : n;
        return sat32(128'(signed'(base)) + capped((m + d2) / (d2 << 1), neg));
    endfunction

    function automatic logic [135:0] predict_points(input logic [191:0] d);
        longint x1, y1, x2, y2, r1, r2, dx, dy, sum, dif, ex, ey, sxp, syp;
        logic signed [127:0] wdx, wdy;
        logic [127:0] d2, q, rem, r1sq, aw, big, asq, h, s, adx, ady, sdx, sdy;
        logic [63:0] t, am, sm;
        logic [31:0] ax, ay, bx, by;
        logic [1:0] cnt;
        logic [2:0] code;
        bit aneg, first_small;
        x1 = $signed(d[31:0]);    y1 = $signed(d[63:32]);   r1 = d[94:64];
        x2 = $signed(d[126:95]);  y2 = $signed(d[158:127]); r2 = d[189:159];
        dx = x2 - x1; dy = y2 - y1;
        wdx = dx; wdy = dy;
        d2 = wdx * wdx + wdy * wdy;
        sum = r1 + r2;
        dif = (r1 > r2) ? r1 - r2 : r2 - r1;
        {ax, ay, bx, by} = '0;
        if (d2 > 128'(sum) * 128'(sum)) begin
            ax = sat32((x1 + x2) >>> 1);
            ay = sat32((y1 + y2) >>> 1);
            cnt = COUNT_ONE; code = CASE_APART;
        end else if (d2 < 128'(dif) * 128'(dif)) begin
            if (d2 == 0) begin
                ax = x1[31:0]; ay = y1[31:0];
                cnt = COUNT_ONE; code = CASE_CONCENTRIC;
            end else begin
                first_small = r1 < r2;
                sxp = first_small ? x1 : x2;
                syp = first_small ? y1 : y2;
                ex = first_small ? -dx : dx;
                ey = first_small ? -dy : dy;
                q = isqrt(d2 << (2 * FRAC), rem);
                t = (64'(sum) << FRAC) - q[63:0];
                ax = sat32(128'(signed'(sxp)) + capped(
                     (128'(ex < 0 ? -ex : ex) * 128'(t) + q) / (q << 1), ex < 0));
                ay = sat32(128'(signed'(syp)) + capped(
                     (128'(ey < 0 ? -ey : ey) * 128'(t) + q) / (q << 1), ey < 0));
                cnt = COUNT_ONE; code = CASE_NESTED;
            end
        end else if (d2 == 0) begin
            cnt = COUNT_NONE; code = CASE_IDENTICAL;
        end else begin
            r1sq = 128'(r1) * 128'(r1);
            aw = d2 + r1sq - 128'(r2) * 128'(r2);
            aneg = aw[127];
            am = aneg ? 64'(-aw) : aw[63:0];
            big = 128'(64'(r1sq[63:0] << 2)) * 128'(d2[63:0]);
            asq = 128'(am) * 128'(am);
            h = (big > asq) ? big - asq : '0;
            s = isqrt(h, rem);
            sm = s[63:0] + ((rem > s) ? 64'd1 : 64'd0);
            adx = signed_prod(am, aneg, dx); ady = signed_prod(am, aneg, dy);
            sdx = signed_prod(sm, 1'b0, dx); sdy = signed_prod(sm, 1'b0, dy);
            ax = offset_point(x1, adx + sdy, d2);
            ay = offset_point(y1, ady - sdx, d2);
            bx = offset_point(x1, adx - sdy, d2);
            by = offset_point(y1, ady + sdx, d2);
            cnt = COUNT_TWO; code = CASE_INTERSECT;
        end
        return {3'b0, code, cnt, by, bx, ay, ax};
    endfunction

    // ---------------- monitors ----------------
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            result_fifo = {result_fifo, predict_points(i_s_axis_tdata)};
    end

    always @(posedge i_clk) begin
        logic [135:0] exp_pts;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (result_fifo.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction %h", o_m_axis_tdata);
            end else begin
                exp_pts = result_fifo.pop_front();
                if (o_m_axis_tdata[31:0] !== exp_pts[31:0]
                    || o_m_axis_tdata[63:32] !== exp_pts[63:32]
                    || o_m_axis_tdata[95:64] !== exp_pts[95:64]
                    || o_m_axis_tdata[127:96] !== exp_pts[127:96]
                    || o_m_axis_tdata[129:128] !== exp_pts[129:128]
                    || o_m_axis_tdata[132:130] !== exp_pts[132:130]
                    || o_m_axis_tdata[135:133] !== exp_pts[135:133]) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected a=(%h,%h) b=(%h,%h) n=%0d c=%0d",
                                 exp_pts[31:0], exp_pts[63:32], exp_pts[95:64],
                                 exp_pts[127:96], exp_pts[129:128], exp_pts[132:130]);
                        $display("          got      a=(%h,%h) b=(%h,%h) n=%0d c=%0d",
                                 o_m_axis_tdata[31:0], o_m_axis_tdata[63:32],
                                 o_m_axis_tdata[95:64], o_m_axis_tdata[127:96],
                                 o_m_axis_tdata[129:128], o_m_axis_tdata[132:130]);
                    end
                end
            end
        end
    end

    // receiver: long hold-off first, then random stalls by phase
    always @(negedge i_clk) begin
        if (hold_count > 0) begin
            i_m_axis_tready = 1'b0;
            hold_count--;
        end else if (idle_mode == 2)
            i_m_axis_tready = ($urandom_range(99) >= 47);
        else if (idle_mode == 3)
            i_m_axis_tready = ($urandom_range(99) >= 11);
        else
            i_m_axis_tready = 1'b1;
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            dog = 0;
        else if (++dog >= DOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic [191:0] pack_pair(input longint x1, y1, r1, x2, y2, r2);
        return {2'b0, r2[30:0], y2[31:0], x2[31:0], r1[30:0], y1[31:0], x1[31:0]};
    endfunction

    task automatic send_pair(input logic [191:0] pair);
        @(negedge i_clk);
        if (idle_mode == 1 || idle_mode == 3) begin
            while ($urandom_range(99) < (idle_mode == 1 ? 47 : 11)) begin
                i_s_axis_tvalid = 1'b0;
                @(negedge i_clk);
            end
        end
        i_s_axis_tdata = pair;
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (result_fifo.size() != 0) @(posedge i_clk);
    endtask

    function automatic longint span(input int bits);
        int v;
        v = $urandom;
        return v >>> (32 - bits);
    endfunction

    function automatic logic [191:0] random_pair();
        longint x1, y1, r1, r2, reach, dx, dy, lo;
        int b;
        b = $urandom_range(4, 29);
        x1 = span(30); y1 = span(30);
        r1 = $urandom & ((1 << b) - 1);
        r2 = $urandom & ((1 << b) - 1);
        case ($urandom_range(9))
            0, 1: return {2'b0, 190'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                      $urandom})};
            2, 3, 4, 5: begin
                // distance along the axes between the radius difference and sum, mostly intersecting
                lo = (r1 > r2) ? r1 - r2 : r2 - r1;
                reach = lo + ({$urandom, $urandom} % (r1 + r2 - lo + 1));
                dx = {$urandom, $urandom} % (reach + 1);
                dy = reach - dx;
                if ($urandom_range(1)) dx = -dx;
                if ($urandom_range(1)) dy = -dy;
                if ($urandom_range(3) == 0) begin
                    dy = 0; dx = ($urandom_range(1) ? reach : -reach);
                end
                return pack_pair(x1, y1, r1, x1 + dx, y1 + dy, r2);
            end
            6, 7: begin
                lo = (r1 > r2) ? r1 - r2 : r2 - r1;
                dx = span(32) % (lo / 2 + 1);
                dy = span(32) % (lo / 2 + 1);
                return pack_pair(x1, y1, r1, x1 + dx, y1 + dy, r2);
            end
            8: return $urandom_range(1) ? pack_pair(x1, y1, r1, x1, y1, r1)
                                        : pack_pair(x1, y1, r1, x1, y1, r2);
            default: return pack_pair(span(32), span(32), r1, span(32), span(32), r2);
        endcase
    endfunction

    task automatic test_directed();
        longint mx, mn, mr;
        mx = 64'sd2147483647; mn = -64'sd2147483648; mr = 64'sd2147483647;
        idle_mode = 0;
        send_pair(pack_pair(0, 0, 0, 0, 0, 0));                 // identical, zero radii
        send_pair(pack_pair(100, -200, 5 << FRAC, 100, -200, 5 << FRAC));
        send_pair(pack_pair(7, 9, 1 << FRAC, 7, 9, 3 << FRAC)); // concentric
        send_pair(pack_pair(mn, mn, 0, mn, mn, mr));
        send_pair(pack_pair(mx, mx, mr, mx, mx, 0));
        send_pair(pack_pair(mn, mn, 0, mx, mx, 0));             // apart, full span
        send_pair(pack_pair(mx, mx, 0, mx, mx - 1, 0));
        send_pair(pack_pair(mn, mn + 1, 0, mn, mn, 0));
        send_pair(pack_pair(0, 0, 3 << FRAC, 4 << FRAC, 0, 2 << FRAC));
        send_pair(pack_pair(-65536, 0, 1 << FRAC, 65536, 0, 1 << FRAC)); // outer tangent
        send_pair(pack_pair(0, 0, 3 << FRAC, 1 << FRAC, 0, 2 << FRAC));  // inner tangent
        send_pair(pack_pair(0, 0, 10 << FRAC, 1 << FRAC, 1 << FRAC, 2 << FRAC)); // nested
        send_pair(pack_pair(1 << FRAC, -3, 2 << FRAC, 0, 0, 10 << FRAC));
        send_pair(pack_pair(mx, mx, 0, mx - 1, mx, mr));        // nested, saturating
        send_pair(pack_pair(mn, mn, mr, mn + 1, mn, 0));
        send_pair(pack_pair(mn, 0, mr, mx, 0, mr));             // apart, huge
        send_pair(pack_pair(0, mn, mr, 0, mx, mr));
        send_pair(pack_pair(0, 0, mr, 1, 1, mr));
        send_pair(pack_pair(mx, mn, mr, mn, mx, mr));
        send_pair(pack_pair(-1, -1, 1, 1, 1, 2));
        wait_drain();
    endtask

    task automatic test_random(input int count);
        for (int mode = 0; mode < 4; mode++) begin
            idle_mode = mode;
            for (int i = 0; i < count; i++) send_pair(random_pair());
        end
        wait_drain();
        idle_mode = 0;
    endtask

    task automatic test_backpressure(input int count);
        idle_mode = 0;
        @(posedge i_clk);
        hold_count = HOLD_LEN;
        for (int i = 0; i < count; i++) send_pair(random_pair());
        wait_drain();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_backpressure(350);
        test_random(350);
        while (result_fifo.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && result_fifo.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: circle_circle_intersection_top.f
rtl/cci_pkg.sv
rtl/cci_sqrt.sv
rtl/cci_div.sv
rtl/circle_circle_intersection_top.sv
rtl/cci_checker.sv
tb/sv/tb_top.sv
